### rtl/hdtl_pkg.sv
// Shared types and character constants for the hex dump text loader.
package hdtl_pkg;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [3:0] LETTER_OFFSET = 4'd9;

   localparam logic [16:0] WINDOW_MAX   = 17'h10000;
   localparam logic [16:0] WINDOW_RESET = 17'd4096;

   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_WINDOW_SIZE  = 1'b1;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef enum logic [2:0] {
      CLS_HEX   = 3'd0,
      CLS_LF    = 3'd1,
      CLS_CR    = 3'd2,
      CLS_NUL   = 3'd3,
      CLS_COLON = 3'd4,
      CLS_OTHER = 3'd5,
      CLS_END   = 3'd6
   } char_class_type;

   typedef enum logic [2:0] {
      PH_ADDR = 3'b001,
      PH_DATA = 3'b010,
      PH_SKIP = 3'b100
   } line_phase_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     nibble;
   } token_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] write_index;
      logic [7:0]  write_data;
      logic [16:0] loaded_length;
      logic        last;
   } result_type;

endpackage

### rtl/hdtl_front.sv
// Front end: classifies each accepted character and queues the token.
module hdtl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [7:0]          char_code,
   input  logic                end_of_text,
   output logic                tok_valid,
   output hdtl_pkg::token_type tok,
   input  logic                tok_pop
);

   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   hdtl_pkg::token_type tok_mem_ff [DEPTH];
   hdtl_pkg::token_type tok_new;
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   always_comb begin
      tok_new.cls    = hdtl_pkg::CLS_OTHER;
      tok_new.nibble = 4'd0;
      if (end_of_text) begin
         tok_new.cls = hdtl_pkg::CLS_END;
      end else if (char_code >= hdtl_pkg::CHAR_DIGIT_0
                && char_code <= hdtl_pkg::CHAR_DIGIT_9) begin
         tok_new.cls    = hdtl_pkg::CLS_HEX;
         tok_new.nibble = char_code[3:0];
      end else if ((char_code >= hdtl_pkg::CHAR_UPPER_A && char_code <= hdtl_pkg::CHAR_UPPER_F)
                || (char_code >= hdtl_pkg::CHAR_LOWER_A && char_code <= hdtl_pkg::CHAR_LOWER_F)) begin
         tok_new.cls    = hdtl_pkg::CLS_HEX;
         tok_new.nibble = char_code[3:0] + hdtl_pkg::LETTER_OFFSET;
      end else if (char_code == hdtl_pkg::CHAR_LF) begin
         tok_new.cls = hdtl_pkg::CLS_LF;
      end else if (char_code == hdtl_pkg::CHAR_CR) begin
         tok_new.cls = hdtl_pkg::CLS_CR;
      end else if (char_code == hdtl_pkg::CHAR_NUL) begin
         tok_new.cls = hdtl_pkg::CLS_NUL;
      end else if (char_code == hdtl_pkg::CHAR_COLON) begin
         tok_new.cls = hdtl_pkg::CLS_COLON;
      end
   end

   assign full      = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign tok_valid = (count_ff != '0);
   assign tok       = tok_mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = tok_pop && tok_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         tok_mem_ff[wr_ptr_ff] <= tok_new;
      end
   end

endmodule

### rtl/hdtl_back.sv
// Back end: line parser, window check, byte writes and the result queue.
module hdtl_back #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   input  hdtl_pkg::token_type  tok,
   output logic                 tok_pop,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [16:0]          csr_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output hdtl_pkg::result_type rsp
);

   localparam int DIFF_BITS = ((ADDR_BITS > 17) ? ADDR_BITS : 17) + 1;
   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   // Configuration
   logic [15:0] base_ff;
   logic [16:0] window_ff;

   // Parser state
   hdtl_pkg::line_phase_type phase_ff, phase_in;
   logic [ADDR_BITS-1:0]     acc_ff, acc_in;
   logic [16:0]              next_index_ff, next_index_in;
   logic                     pending_ff, pending_in;
   logic [3:0]               nibble_ff, nibble_in;
   logic [16:0]              high_water_ff, high_water_in;

   // Result queue
   hdtl_pkg::result_type res_mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]    count_ff, count_in;
   logic                 out_full;
   logic                 out_pop;

   hdtl_pkg::result_type res;
   logic                 res_push;
   logic                 emit_req;
   logic [7:0]           emit_data;
   logic                 emit_last;
   logic                 emit_ok;
   logic [16:0]          index_plus;
   logic [DIFF_BITS-1:0] addr_diff;
   logic                 in_window;

   assign out_full  = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp       = res_mem_ff[rd_ptr_ff];
   assign out_pop   = rsp_pop && !rsp_empty;

   assign emit_ok    = (next_index_ff < window_ff);
   assign index_plus = next_index_ff + 17'd1;
   assign addr_diff  = DIFF_BITS'(acc_ff) - DIFF_BITS'(base_ff);
   assign in_window  = (DIFF_BITS'(acc_ff) >= DIFF_BITS'(base_ff))
                    && (addr_diff < DIFF_BITS'(window_ff));

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      next_index_in = next_index_ff;
      pending_in    = pending_ff;
      nibble_in     = nibble_ff;
      high_water_in = high_water_ff;
      tok_pop       = 1'b0;
      res_push      = 1'b0;
      res           = '0;
      emit_req      = 1'b0;
      emit_data     = 8'd0;
      emit_last     = 1'b1;

      if (tok_valid && !out_full) begin
         if (tok.cls == hdtl_pkg::CLS_END) begin
            if (phase_ff == hdtl_pkg::PH_DATA && pending_ff) begin
               // The open one-digit token goes out first; the end token stays
               // at the head of the queue and finishes once the result queue has room.
               emit_req   = 1'b1;
               emit_data  = {4'd0, nibble_ff};
               emit_last  = 1'b0;
               pending_in = 1'b0;
               nibble_in  = 4'd0;
            end else begin
               tok_pop             = 1'b1;
               res_push            = 1'b1;
               res.kind            = hdtl_pkg::KIND_FINISH;
               res.loaded_length   = high_water_ff;
               res.last            = 1'b1;
               phase_in            = hdtl_pkg::PH_ADDR;
               acc_in              = '0;
               next_index_in       = '0;
               pending_in          = 1'b0;
               nibble_in           = 4'd0;
               high_water_in       = '0;
            end
         end else begin
            tok_pop = 1'b1;
            unique case (phase_ff)
               hdtl_pkg::PH_ADDR: begin
                  priority if (tok.cls == hdtl_pkg::CLS_HEX) begin
                     acc_in = {acc_ff[ADDR_BITS-5:0], tok.nibble};
                  end else if (tok.cls == hdtl_pkg::CLS_LF) begin
                     acc_in = '0;
                  end else if (tok.cls == hdtl_pkg::CLS_NUL) begin
                     phase_in = hdtl_pkg::PH_SKIP;
                  end else if (tok.cls == hdtl_pkg::CLS_COLON) begin
                     if (in_window) begin
                        next_index_in = addr_diff[16:0];
                        pending_in    = 1'b0;
                        nibble_in     = 4'd0;
                        phase_in      = hdtl_pkg::PH_DATA;
                     end else begin
                        phase_in = hdtl_pkg::PH_SKIP;
                     end
                  end else begin
                     phase_in = phase_ff;
                  end
               end
               hdtl_pkg::PH_DATA: begin
                  if (tok.cls == hdtl_pkg::CLS_HEX) begin
                     if (pending_ff) begin
                        emit_req   = 1'b1;
                        emit_data  = {nibble_ff, tok.nibble};
                        pending_in = 1'b0;
                        nibble_in  = 4'd0;
                     end else begin
                        pending_in = 1'b1;
                        nibble_in  = tok.nibble;
                     end
                  end else begin
                     if (pending_ff) begin
                        emit_req   = 1'b1;
                        emit_data  = {4'd0, nibble_ff};
                        pending_in = 1'b0;
                        nibble_in  = 4'd0;
                     end
                     if (tok.cls == hdtl_pkg::CLS_LF) begin
                        phase_in = hdtl_pkg::PH_ADDR;
                        acc_in   = '0;
                     end else if (tok.cls == hdtl_pkg::CLS_CR
                               || tok.cls == hdtl_pkg::CLS_NUL) begin
                        phase_in = hdtl_pkg::PH_SKIP;
                     end
                  end
               end
               hdtl_pkg::PH_SKIP: begin
                  if (tok.cls == hdtl_pkg::CLS_LF) begin
                     phase_in = hdtl_pkg::PH_ADDR;
                     acc_in   = '0;
                  end
               end
               default: begin
                  phase_in = hdtl_pkg::PH_ADDR;
               end
            endcase
         end

         // Writes past the end of the window are parsed but dropped.
         if (emit_req && emit_ok) begin
            res_push          = 1'b1;
            res.kind          = hdtl_pkg::KIND_WRITE;
            res.write_index   = next_index_ff[15:0];
            res.write_data    = emit_data;
            res.last          = emit_last;
            next_index_in     = index_plus;
            if (index_plus > high_water_ff) begin
               high_water_in = index_plus;
            end
         end
      end
   end

   assign count_in = count_ff + (PTR_BITS+1)'(res_push) - (PTR_BITS+1)'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         window_ff     <= hdtl_pkg::WINDOW_RESET;
         phase_ff      <= hdtl_pkg::PH_ADDR;
         acc_ff        <= '0;
         next_index_ff <= '0;
         pending_ff    <= 1'b0;
         nibble_ff     <= 4'd0;
         high_water_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == hdtl_pkg::CSR_BASE_ADDRESS) begin
               base_ff <= csr_data[15:0];
            end else begin
               window_ff <= (csr_data > hdtl_pkg::WINDOW_MAX) ? hdtl_pkg::WINDOW_MAX
                                                              : csr_data;
            end
         end
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         next_index_ff <= next_index_in;
         pending_ff    <= pending_in;
         nibble_ff     <= nibble_in;
         high_water_ff <= high_water_in;
         if (res_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (out_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_mem_ff[wr_ptr_ff] <= res;
      end
   end

`ifndef SYNTHESIS
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      next_index_ff <= hdtl_pkg::WINDOW_MAX)
      else $error("next index ran past the largest window");

   a_high_water_bound: assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= hdtl_pkg::WINDOW_MAX)
      else $error("high water mark ran past the largest window");

   a_pending_in_data: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (phase_ff == hdtl_pkg::PH_DATA))
      else $error("open digit outside the data phase");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.kind == hdtl_pkg::KIND_FINISH)
      |=> (phase_ff == hdtl_pkg::PH_ADDR && high_water_ff == '0 && !pending_ff))
      else $error("parser state not cleared after finish");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_BITS+1)'(DEPTH))
      else $error("result queue overflow");
`endif

endmodule

### rtl/hex_dump_text_loader.sv
// Top level of the hex dump text loader: front classifier, token queue and back end.
//
// The request side is a queue input: drive req_char_code and req_end_of_text
// and raise req_push; the transaction is taken at a rising edge with req_full
// low. Each character is classified and stored in a four-entry token queue.
// The back end takes one token per cycle while the result queue has room, runs
// the line parser and places results in a four-entry result queue. The result
// side reads like a queue: while rsp_empty is low the oldest result sits on the
// rsp_ ports, and it is taken at a rising edge with rsp_pop high.
// Characters are registered in the token queue and results in the result queue.
// Throughput: one character per cycle while req_full is low; an end of text that
// closes an open one-digit byte token gives the byte first, then the finish result.
// When the receiver stalls, the result queue fills, the back end holds, then
// the token queue fills and req_full rises; nothing is lost.
// Configuration: csr_write with csr_index selects base_address (0) or
// window_size (1); write only while the block is idle. Windows above 65536
// act as 65536.
// Synchronous reset empties both queues, returns the parser to the address
// phase and sets base_address to 0 and window_size to 4096.
module hex_dump_text_loader #(
   parameter int ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [15:0] rsp_write_index,
   output logic [7:0]  rsp_write_data,
   output logic [16:0] rsp_loaded_length,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [16:0] csr_data
);

   // Tokens flow from the front end to the back end through this handshake.
   hdtl_pkg::token_type  tok;
   logic                 tok_valid;
   logic                 tok_pop;
   hdtl_pkg::result_type rsp;

   hdtl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .tok_valid   (tok_valid),
      .tok         (tok),
      .tok_pop     (tok_pop)
   );

   hdtl_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok       (tok),
      .tok_pop   (tok_pop),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   // The stored result record is split onto the individual result ports.
   assign rsp_kind          = rsp.kind;
   assign rsp_write_index   = rsp.write_index;
   assign rsp_write_data    = rsp.write_data;
   assign rsp_loaded_length = rsp.loaded_length;
   assign rsp_last          = rsp.last;

endmodule
